// ===== rtl/buddy_block_allocator_assert.svh =====
// Assertion helpers for the buddy allocator.
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define BBA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("buddy allocator check failed");

// Next-cycle implication.
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("buddy allocator check failed");

`endif

// ===== rtl/bba_pkg.sv =====
package bba_pkg;

   localparam int TREE_LEVELS  = 8;
   localparam int HEADER_BYTES = 4;
   localparam int MAX_MIN_LOG2 = 16;
   localparam int NODES        = (1 << TREE_LEVELS) - 1;
   localparam int NODE_W       = TREE_LEVELS;
   localparam int WIDE_W       = NODE_W + 1;
   localparam int LVL_W        = (TREE_LEVELS > 1) ? $clog2(TREE_LEVELS) : 1;
   localparam int LCNT_W       = 4;
   localparam int MLOG_W       = 5;
   localparam int BYTES_W      = 24;
   localparam int SIZE_W       = BYTES_W + 1;
   localparam int SCAN_STEP    = 8;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BAD_SIZE = 3'd1;
   localparam logic [2:0] ST_NO_MEM   = 3'd2;
   localparam logic [2:0] ST_BAD_IDX  = 3'd3;
   localparam logic [2:0] ST_IS_FREE  = 3'd4;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic REG_LEVELS   = 1'b0;
   localparam logic REG_MIN_LOG2 = 1'b1;

   localparam logic [2:0] OP_IDLE  = 3'd0;
   localparam logic [2:0] OP_CHECK = 3'd1;
   localparam logic [2:0] OP_SCAN  = 3'd2;
   localparam logic [2:0] OP_ANC   = 3'd3;
   localparam logic [2:0] OP_FILL  = 3'd4;
   localparam logic [2:0] OP_BUDDY = 3'd5;
   localparam logic [2:0] OP_FIN   = 3'd6;

   typedef struct packed {
      logic       load;
      logic [2:0] op;
   } cmd_type;

   typedef struct packed {
      logic is_alloc;
      logic chk_err;
      logic scan_found;
      logic scan_end;
      logic anc_root;
      logic fill_done;
      logic buddy_stop;
      logic rsp_free;
   } stat_type;

endpackage

// ===== rtl/bba_if.sv =====
interface bba_req_if;
   import bba_pkg::*;
   logic                valid;
   logic                ready;
   logic                kind;
   logic [BYTES_W-1:0]  request_bytes;
   logic [NODE_W-1:0]   free_node;
   modport source (output valid, kind, request_bytes, free_node, input ready);
   modport sink   (input valid, kind, request_bytes, free_node, output ready);
endinterface

interface bba_rsp_if;
   import bba_pkg::*;
   logic                valid;
   logic                ready;
   logic [2:0]          status;
   logic [NODE_W-1:0]   node_index;
   logic [BYTES_W-1:0]  block_offset;
   logic [4:0]          block_size_log2;
   modport source (output valid, status, node_index, block_offset, block_size_log2,
                   input ready);
   modport sink   (input valid, status, node_index, block_offset, block_size_log2,
                   output ready);
endinterface

interface bba_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [4:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/buddy_block_allocator.sv =====
// Binary buddy allocator over a 255-node busy bitmap tree.
// req: one beat per request. kind 0 allocates request_bytes (plus a 4-byte
//   header), kind 1 frees the block at tree node free_node.
// rsp: one beat per request with status, node_index, block_offset and
//   block_size_log2; error beats carry zeros in the other fields.
// csr: register 0 is levels_in_use, register 1 is min_block_log2; write only
//   while no request is in flight. csr.ready is always high.
// Sequencing: one request at a time; req.ready is high only while idle.
//   An allocate checks the request, scans the level that fits it, marks the
//   path from the found block up to the root busy and then marks the block's
//   subtree busy level by level; if the scan finds no free node it ends there.
//   A free checks the node, clears its subtree level by level and merges free
//   buddies into their parents. A request rejected at the check goes straight
//   to the result. The level scan takes 8 nodes a cycle; the path walks take one node per cycle.
// Reset: all nodes free, levels_in_use 8, min_block_log2 4; no setup needed.
// A result sits in the output register; req.ready returns once it is loaded,
//   so a new request is taken while the previous beat waits. If the earlier
//   beat is still not taken when the next result is done, the block holds.
module buddy_block_allocator
   import bba_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   bba_req_if.sink   req,
   bba_rsp_if.source rsp,
   bba_csr_if.sink   csr
);

   `include "buddy_block_allocator_assert.svh"

   cmd_type  cmd;
   stat_type stat;

   assign csr.ready = 1'b1;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bba_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_kind      (req.kind),
      .req_bytes     (req.request_bytes),
      .req_node      (req.free_node),
      .csr_valid     (csr.valid),
      .csr_index     (csr.index),
      .csr_data      (csr.data),
      .rsp_valid     (rsp.valid),
      .rsp_ready     (rsp.ready),
      .rsp_status    (rsp.status),
      .rsp_node      (rsp.node_index),
      .rsp_offset    (rsp.block_offset),
      .rsp_size_log2 (rsp.block_size_log2)
   );

   `BBA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req.valid && req.ready, !req.ready)
   `BBA_ASSERT_NOW(a_error_zero, clock, reset, rsp.valid && (rsp.status != ST_OK),
      (rsp.node_index == '0) && (rsp.block_offset == '0) && (rsp.block_size_log2 == '0))
   `BBA_ASSERT_NOW(a_rsp_after_work, clock, reset, $rose(rsp.valid), $past(!req.ready))

endmodule

// ===== rtl/bba_ctrl.sv =====
module bba_ctrl
   import bba_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_ANC   = 3'd3;
   localparam logic [2:0] S_FILL  = 3'd4;
   localparam logic [2:0] S_BUDDY = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.load = 1'b0;
      cmd.op   = OP_IDLE;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = req_valid;
            if (req_valid) state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.op = OP_CHECK;
            if (stat.chk_err) state_in = S_FIN;
            else if (stat.is_alloc) state_in = S_SCAN;
            else state_in = S_FILL;
         end
         S_SCAN: begin
            cmd.op = OP_SCAN;
            if (stat.scan_found) state_in = S_ANC;
            else if (stat.scan_end) state_in = S_FIN;
         end
         S_ANC: begin
            cmd.op = OP_ANC;
            if (stat.anc_root) state_in = S_FILL;
         end
         S_FILL: begin
            cmd.op = OP_FILL;
            if (stat.fill_done) state_in = stat.is_alloc ? S_FIN : S_BUDDY;
         end
         S_BUDDY: begin
            cmd.op = OP_BUDDY;
            if (stat.buddy_stop) state_in = S_FIN;
         end
         S_FIN: begin
            cmd.op = OP_FIN;
            if (stat.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ===== rtl/bba_dpath.sv =====
module bba_dpath
   import bba_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic               req_kind,
   input  logic [BYTES_W-1:0] req_bytes,
   input  logic [NODE_W-1:0]  req_node,
   input  logic               csr_valid,
   input  logic               csr_index,
   input  logic [4:0]         csr_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [NODE_W-1:0]  rsp_node,
   output logic [BYTES_W-1:0] rsp_offset,
   output logic [4:0]         rsp_size_log2
);

   logic [LCNT_W-1:0]  levels_ff;
   logic [MLOG_W-1:0]  mlog_ff;
   logic [NODES-1:0]   tree_ff;
   logic               kind_ff;
   logic [BYTES_W-1:0] bytes_ff;
   logic [NODE_W-1:0]  node_ff, anc_ff;
   logic [LVL_W-1:0]   lvl_ff;
   logic [4:0]         blog_ff;
   logic [WIDE_W-1:0]  pos_ff, end_ff, start_ff, count_ff;
   logic [2:0]         res_st_ff;
   logic [NODE_W-1:0]  res_node_ff;
   logic [BYTES_W-1:0] res_off_ff;
   logic [4:0]         res_szl_ff;
   logic               rsp_valid_ff;
   logic [2:0]         rsp_st_ff;
   logic [NODE_W-1:0]  rsp_node_ff;
   logic [BYTES_W-1:0] rsp_off_ff;
   logic [4:0]         rsp_szl_ff;

   logic [LCNT_W-1:0]  eff_l;
   logic [MLOG_W-1:0]  eff_m;
   logic [WIDE_W-1:0]  nbits;
   logic [SIZE_W-1:0]  heap_bytes, need;
   logic [5:0]         mem_shift;
   logic               bad_size, fit_any, node_busy, node_bad;
   logic [LVL_W-1:0]   fit_k, lvl_c;
   logic [4:0]         blog_c;
   logic [WIDE_W-1:0]  first_c, end_c, first_cur, scan_p, found_p;
   logic               found;
   logic [NODE_W-1:0]  buddy, parent;
   logic [WIDE_W:0]    fill_hi;
   logic [31:0]        off_wide;

   always_comb begin
      eff_l = (levels_ff == '0) ? LCNT_W'(1) :
              (levels_ff > LCNT_W'(TREE_LEVELS)) ? LCNT_W'(TREE_LEVELS) : levels_ff;
      eff_m = (mlog_ff > MLOG_W'(MAX_MIN_LOG2)) ? MLOG_W'(MAX_MIN_LOG2) : mlog_ff;
      nbits = (WIDE_W'(1) << eff_l) - WIDE_W'(1);
      mem_shift = 6'(eff_m) + 6'(eff_l) - 6'd1;
      heap_bytes = SIZE_W'(1) << mem_shift;
      bad_size = (bytes_ff == '0) || ({1'b0, bytes_ff} > heap_bytes);
      need = {1'b0, bytes_ff} + SIZE_W'(HEADER_BYTES);
      fit_any = 1'b0;
      fit_k = '0;
      for (int k = TREE_LEVELS - 1; k >= 0; k--) begin
         if ((k < int'(eff_l)) && (need <= (SIZE_W'(1) << (int'(eff_m) + k)))) begin
            fit_any = 1'b1;
            fit_k = LVL_W'(k);
         end
      end
      lvl_c = LVL_W'(eff_l - LCNT_W'(1) - LCNT_W'(fit_k));
      blog_c = 5'(eff_m) + 5'(fit_k);
      first_c = (WIDE_W'(1) << lvl_c) - WIDE_W'(1);
      end_c = (WIDE_W'(1) << (lvl_c + 1)) - WIDE_W'(1);
      first_cur = (WIDE_W'(1) << lvl_ff) - WIDE_W'(1);
      node_bad = ({1'b0, node_ff} >= nbits);
      node_busy = !node_bad && tree_ff[node_ff];

      found = 1'b0;
      found_p = '0;
      for (int b = SCAN_STEP - 1; b >= 0; b--) begin
         scan_p = pos_ff + WIDE_W'(b);
         if ((scan_p < end_ff) && !tree_ff[scan_p[NODE_W-1:0]]) begin
            found = 1'b1;
            found_p = scan_p;
         end
      end
      off_wide = 32'(found_p - first_cur) << blog_ff;

      parent = (anc_ff - NODE_W'(1)) >> 1;
      buddy = anc_ff[0] ? anc_ff + NODE_W'(1) : anc_ff - NODE_W'(1);
      fill_hi = {1'b0, start_ff} + {1'b0, count_ff};

      stat.is_alloc   = (kind_ff == KIND_ALLOC);
      stat.chk_err    = (kind_ff == KIND_ALLOC) ? (bad_size || !fit_any) : !node_busy;
      stat.scan_found = found;
      stat.scan_end   = ((pos_ff + WIDE_W'(SCAN_STEP)) >= end_ff);
      stat.anc_root   = (anc_ff == '0);
      stat.fill_done  = (start_ff >= nbits);
      stat.buddy_stop = (anc_ff == '0) || tree_ff[buddy];
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= LCNT_W'(TREE_LEVELS);
         mlog_ff   <= MLOG_W'(4);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_LEVELS:   levels_ff <= csr_data[LCNT_W-1:0];
            REG_MIN_LOG2: mlog_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         bytes_ff <= req_bytes;
         node_ff  <= req_node;
      end
      case (cmd.op)
         OP_CHECK: begin
            res_node_ff <= ((kind_ff == KIND_FREE) && node_busy) ? node_ff : '0;
            res_off_ff  <= '0;
            res_szl_ff  <= '0;
            anc_ff      <= node_ff;
            start_ff    <= {1'b0, node_ff};
            count_ff    <= WIDE_W'(1);
            lvl_ff      <= lvl_c;
            blog_ff     <= blog_c;
            pos_ff      <= first_c;
            end_ff      <= end_c;
            if (kind_ff == KIND_ALLOC) begin
               res_st_ff <= bad_size ? ST_BAD_SIZE : ST_NO_MEM;
            end else if (node_bad) begin
               res_st_ff <= ST_BAD_IDX;
            end else if (!node_busy) begin
               res_st_ff <= ST_IS_FREE;
            end else begin
               res_st_ff <= ST_OK;
            end
         end
         OP_SCAN: begin
            pos_ff <= pos_ff + WIDE_W'(SCAN_STEP);
            if (found) begin
               anc_ff      <= found_p[NODE_W-1:0];
               start_ff    <= found_p;
               count_ff    <= WIDE_W'(1);
               res_st_ff   <= ST_OK;
               res_node_ff <= found_p[NODE_W-1:0];
               res_off_ff  <= off_wide[BYTES_W-1:0];
               res_szl_ff  <= blog_ff;
            end
         end
         OP_ANC: begin
            if (anc_ff != '0) anc_ff <= parent;
         end
         OP_FILL: begin
            start_ff <= WIDE_W'({start_ff, 1'b1});
            count_ff <= count_ff << 1;
         end
         OP_BUDDY: begin
            if (!stat.buddy_stop) anc_ff <= parent;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tree_ff <= '0;
      end else begin
         case (cmd.op)
            OP_ANC: tree_ff[anc_ff] <= 1'b1;
            OP_FILL: begin
               if (!stat.fill_done) begin
                  for (int j = 0; j < NODES; j++) begin
                     if ((WIDE_W'(j) >= start_ff) && ((WIDE_W + 1)'(j) < fill_hi))
                        tree_ff[j] <= (kind_ff == KIND_ALLOC);
                  end
               end
            end
            OP_BUDDY: begin
               if (!stat.buddy_stop) tree_ff[parent] <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ((cmd.op == OP_FIN) && stat.rsp_free) ||
                         (rsp_valid_ff && !rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.op == OP_FIN) && stat.rsp_free) begin
         rsp_st_ff   <= res_st_ff;
         rsp_node_ff <= res_node_ff;
         rsp_off_ff  <= res_off_ff;
         rsp_szl_ff  <= res_szl_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_st_ff;
   assign rsp_node      = rsp_node_ff;
   assign rsp_offset    = rsp_off_ff;
   assign rsp_size_log2 = rsp_szl_ff;

endmodule
